// ----- hw/rtl/rpsb_pkg.sv -----
// Shared types, constants and register codes for the read pair score tracker.
package rpsb_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int BONUS_W     = 20;
    localparam int QUOT_W      = 26;
    localparam int DIV_W       = 10;

    localparam logic signed [31:0] SCORE_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] HALF_MIN_BOTH  = 32'shBFFF_FFFF;
    localparam logic signed [31:0] HALF_MIN_ONE   = 32'shC000_0000;
    localparam logic [15:0]        COUNT_MAX      = 16'hFFFF;

    // Reciprocals for exact division of a 32-bit distance: the estimate is
    // at most one below the true quotient and is corrected afterwards.
    localparam logic [31:0]        RECIP_DNA      = 32'd2748779069;
    localparam logic [31:0]        RECIP_RNA      = 32'd2199023255;
    localparam logic [DIV_W-1:0]   DIV_DNA        = 10'd100;
    localparam logic [DIV_W-1:0]   DIV_RNA        = 10'd1000;

    localparam logic [31:0]        MAX_DIST_RST   = 32'd500000;
    localparam logic [31:0]        DNA_START_RST  = 32'd1000;
    localparam logic [31:0]        RNA_START_RST  = 32'd100000;
    localparam logic [BONUS_W-1:0] BONUS_RST      = 20'd500000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RNA_MODE      = 3'd0,
        CFG_MAX_DISTANCE  = 3'd1,
        CFG_DNA_START     = 3'd2,
        CFG_RNA_START     = 3'd3,
        CFG_BONUS         = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_SEGMENT,
        KIND_UNMAPPED_BOTH,
        KIND_UNMAPPED_ONE,
        KIND_MAPPED
    } t_kind;

    typedef struct packed {
        logic               rna_mode;
        logic [31:0]        max_pair_distance;
        logic [31:0]        dna_penalty_start;
        logic [31:0]        rna_penalty_start;
        logic [BONUS_W-1:0] concordant_bonus;
    } t_cfg;

    typedef struct packed {
        logic               new_read;
        logic signed [31:0] score;
        logic               count;
        logic               conc;
    } t_pair;

    typedef struct packed {
        logic  valid;
        t_pair pair;
    } t_beat;

endpackage

// ----- hw/rtl/rpsb_front.sv -----
// Front pipeline: accepts candidate pairs and computes the pair score in three stages.
module rpsb_front
    import rpsb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cfg                              i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_new_read,
    input  logic [31:0]                       i_loc_first,
    input  logic [31:0]                       i_loc_second,
    input  logic signed [15:0]                i_score_first,
    input  logic signed [15:0]                i_score_second,
    input  logic                              i_fwd_first,
    input  logic                              i_fwd_second,
    input  logic                              i_mapped_first,
    input  logic                              i_mapped_second,
    input  logic                              i_same_segment,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  i_level,
    output t_beat                             o_push
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW = CW + 1;

    logic               w_accept;
    logic [BW-1:0]      w_busy;
    logic [31:0]        w_dist;
    logic               w_faces;
    logic signed [16:0] w_sum;
    t_kind              w_kind;

    // Stage 1: distance, orientation, score sum, class.
    logic               r_v1, r_new1, r_faces1;
    t_kind              r_kind1;
    logic [31:0]        r_dist1;
    logic signed [16:0] r_sum1;

    // Stage 2: reciprocal product, scaled base score, limit compares.
    logic signed [24:0] w_scaled;
    logic signed [31:0] w_base;
    logic [63:0]        w_prod;
    logic               r_v2, r_new2, r_faces2, r_far2, r_pen2;
    t_kind              r_kind2;
    logic [31:0]        r_dist2;
    logic signed [31:0] r_base2;
    logic [63:0]        r_prod2;

    // Stage 3: quotient estimate and its back product.
    logic [QUOT_W-1:0]  w_est;
    logic [DIV_W-1:0]   w_div;
    logic [35:0]        w_estd;
    logic               r_v3, r_new3, r_faces3, r_far3, r_pen3;
    t_kind              r_kind3;
    logic [31:0]        r_dist3;
    logic signed [31:0] r_base3;
    logic [QUOT_W-1:0]  r_est3;
    logic [31:0]        r_estd3;

    logic [31:0]        w_rem;
    logic [QUOT_W-1:0]  w_quot;
    logic signed [31:0] w_mapped_score;

    // Credit check: every beat in flight already owns a queue slot.
    assign w_busy     = BW'(i_level) + BW'(r_v1) + BW'(r_v2) + BW'(r_v3);
    assign o_in_stall = (w_busy >= BW'(QUEUE_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_dist  = (i_loc_first > i_loc_second) ? (i_loc_first - i_loc_second)
                                               : (i_loc_second - i_loc_first);
        w_faces = (i_loc_first < i_loc_second) ? (i_fwd_first && !i_fwd_second)
                                               : (!i_fwd_first && i_fwd_second);
        w_sum   = 17'(i_score_first) + 17'(i_score_second);
        if (i_same_segment) begin
            w_kind = KIND_SEGMENT;
        end else if (!i_mapped_first && !i_mapped_second) begin
            w_kind = KIND_UNMAPPED_BOTH;
        end else if (!i_mapped_first || !i_mapped_second) begin
            w_kind = KIND_UNMAPPED_ONE;
        end else begin
            w_kind = KIND_MAPPED;
        end
    end

    always_comb begin
        w_scaled = $signed({{8{r_sum1[16]}}, r_sum1}) * 25'sd100;
        w_base   = i_cfg.rna_mode ? -32'(w_scaled) : 32'(w_scaled);
        w_prod   = {32'd0, r_dist1} * {32'd0, (i_cfg.rna_mode ? RECIP_RNA : RECIP_DNA)};
    end

    always_comb begin
        w_div  = i_cfg.rna_mode ? DIV_RNA : DIV_DNA;
        w_est  = i_cfg.rna_mode ? QUOT_W'(r_prod2[63:41]) : r_prod2[63:38];
        w_estd = {10'd0, w_est} * {26'd0, w_div};
    end

    always_comb begin
        w_rem  = r_dist3 - r_estd3;
        w_quot = r_est3 + ((w_rem >= 32'(w_div)) ? QUOT_W'(1) : QUOT_W'(0));
        w_mapped_score = r_base3
                       - (r_pen3   ? 32'(w_quot) : 32'd0)
                       + (r_faces3 ? 32'(i_cfg.concordant_bonus) : 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new1   <= i_new_read;
        r_kind1  <= w_kind;
        r_faces1 <= w_faces;
        r_dist1  <= w_dist;
        r_sum1   <= w_sum;

        r_new2   <= r_new1;
        r_kind2  <= r_kind1;
        r_faces2 <= r_faces1;
        r_dist2  <= r_dist1;
        r_far2   <= (r_dist1 > i_cfg.max_pair_distance);
        r_pen2   <= (r_dist1 > (i_cfg.rna_mode ? i_cfg.rna_penalty_start
                                               : i_cfg.dna_penalty_start));
        r_base2  <= w_base;
        r_prod2  <= w_prod;

        r_new3   <= r_new2;
        r_kind3  <= r_kind2;
        r_faces3 <= r_faces2;
        r_far3   <= r_far2;
        r_pen3   <= r_pen2;
        r_dist3  <= r_dist2;
        r_base3  <= r_base2;
        r_est3   <= w_est;
        r_estd3  <= w_estd[31:0];
    end

    always_comb begin
        o_push.valid         = r_v3;
        o_push.pair.new_read = r_new3;
        o_push.pair.score    = SCORE_MIN;
        o_push.pair.count    = 1'b0;
        o_push.pair.conc     = 1'b0;
        unique case (r_kind3)
            KIND_SEGMENT: begin
                o_push.pair.score = SCORE_MIN;
            end
            KIND_UNMAPPED_BOTH: begin
                o_push.pair.score = HALF_MIN_BOTH;
            end
            KIND_UNMAPPED_ONE: begin
                o_push.pair.score = HALF_MIN_ONE;
                o_push.pair.count = 1'b1;
            end
            KIND_MAPPED: begin
                o_push.pair.count = 1'b1;
                if (r_far3) begin
                    o_push.pair.score = SCORE_MIN;
                end else begin
                    o_push.pair.score = w_mapped_score;
                    o_push.pair.conc  = r_faces3;
                end
            end
            default: begin
                o_push.pair.score = SCORE_MIN;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rpsb_queue.sv -----
// Small queue of scored pairs between the front pipeline and the best tracker.
module rpsb_queue
    import rpsb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_beat                             i_push,
    input  logic                              i_pop,
    output t_beat                             o_head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  o_level
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_pair         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_level;
    logic          w_pop;

    assign w_pop          = i_pop && (r_level != '0);
    assign o_head.valid   = (r_level != '0);
    assign o_head.pair    = r_mem[r_rd_ptr];
    assign o_level        = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_level <= r_level + CW'(i_push.valid) - CW'(w_pop);
        end
    end

endmodule

// ----- hw/rtl/rpsb_back.sv -----
// Best tracker: compares each scored pair with the running best and registers the result.
module rpsb_back
    import rpsb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_beat              i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pair_score,
    output logic               o_pair_count,
    output logic               o_concordant,
    output logic               o_kept,
    output logic signed [31:0] o_best_score_out,
    output logic [15:0]        o_best_count_out,
    output logic               o_any_concordant
);

    logic               r_out_valid;
    logic signed [31:0] r_best, n_best;
    logic [15:0]        r_count, n_count;
    logic               r_conc, n_conc;
    logic               n_kept;
    logic signed [31:0] w_old_best;
    logic [15:0]        w_old_count;
    logic               w_old_conc;
    logic [16:0]        w_sum;

    logic signed [31:0] r_pair_score;
    logic               r_pair_count, r_pair_conc, r_kept;

    assign o_pop = i_head.valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_old_best  = i_head.pair.new_read ? SCORE_MIN : r_best;
        w_old_count = i_head.pair.new_read ? 16'd0     : r_count;
        w_old_conc  = i_head.pair.new_read ? 1'b0      : r_conc;
        w_sum       = 17'(w_old_count) + 17'(i_head.pair.count);
        n_best      = w_old_best;
        n_count     = w_old_count;
        n_conc      = w_old_conc;
        n_kept      = 1'b0;
        if (i_head.pair.score > w_old_best) begin
            n_best  = i_head.pair.score;
            n_count = 16'(i_head.pair.count);
            n_conc  = i_head.pair.conc;
            n_kept  = 1'b1;
        end else if (i_head.pair.score == w_old_best) begin
            n_count = w_sum[16] ? COUNT_MAX : w_sum[15:0];
            n_kept  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_best      <= SCORE_MIN;
            r_count     <= 16'd0;
            r_conc      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_best      <= n_best;
                r_count     <= n_count;
                r_conc      <= n_conc;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pair_score <= i_head.pair.score;
            r_pair_count <= i_head.pair.count;
            r_pair_conc  <= i_head.pair.conc;
            r_kept       <= n_kept;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pair_score     = r_pair_score;
    assign o_pair_count     = r_pair_count;
    assign o_concordant     = r_pair_conc;
    assign o_kept           = r_kept;
    assign o_best_score_out = r_best;
    assign o_best_count_out = r_count;
    assign o_any_concordant = r_conc;

endmodule

// ----- hw/rtl/read_pair_score_best_tracker.sv -----
// Throughput: one beat per cycle while o_in_stall is low; the three-stage scoring pipeline never stalls internally.
// Input stall rises when queued plus in-flight beats fill the queue depth (QUEUE_DEPTH).
// Reset is synchronous and active low; it empties pipeline, queue and output register,
// sets the best score to the minimum with zero ties, and loads the register defaults.
// There is no clearing pass: the block accepts beats as soon as reset is released.
module read_pair_score_best_tracker
    import rpsb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_new_read,
    input  logic [31:0]             i_loc_first,
    input  logic [31:0]             i_loc_second,
    input  logic signed [15:0]      i_score_first,
    input  logic signed [15:0]      i_score_second,
    input  logic                    i_fwd_first,
    input  logic                    i_fwd_second,
    input  logic                    i_mapped_first,
    input  logic                    i_mapped_second,
    input  logic                    i_same_segment,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [31:0]      o_pair_score,
    output logic                    o_pair_count,
    output logic                    o_concordant,
    output logic                    o_kept,
    output logic signed [31:0]      o_best_score_out,
    output logic [15:0]             o_best_count_out,
    output logic                    o_any_concordant
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cfg          r_cfg;
    t_beat         w_push;
    t_beat         w_head;
    logic          w_pop;
    logic [CW-1:0] w_level;

    // The configuration port takes a beat every cycle. The user must write the registers only
    // while the block is idle, so the pipeline reads them directly; the block does not enforce it.
    // Writes to an index that names no register are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rna_mode          <= 1'b0;
            r_cfg.max_pair_distance <= MAX_DIST_RST;
            r_cfg.dna_penalty_start <= DNA_START_RST;
            r_cfg.rna_penalty_start <= RNA_START_RST;
            r_cfg.concordant_bonus  <= BONUS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RNA_MODE:     r_cfg.rna_mode          <= i_cfg_data[0];
                CFG_MAX_DISTANCE: r_cfg.max_pair_distance <= i_cfg_data;
                CFG_DNA_START:    r_cfg.dna_penalty_start <= i_cfg_data;
                CFG_RNA_START:    r_cfg.rna_penalty_start <= i_cfg_data;
                CFG_BONUS:        r_cfg.concordant_bonus  <= i_cfg_data[BONUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front computes the distance, class and score of each pair. The
    // distance divided by 100 or 1000 comes from a reciprocal multiply that
    // is corrected by one compare against the remainder.
    rpsb_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_new_read      (i_new_read),
        .i_loc_first     (i_loc_first),
        .i_loc_second    (i_loc_second),
        .i_score_first   (i_score_first),
        .i_score_second  (i_score_second),
        .i_fwd_first     (i_fwd_first),
        .i_fwd_second    (i_fwd_second),
        .i_mapped_first  (i_mapped_first),
        .i_mapped_second (i_mapped_second),
        .i_same_segment  (i_same_segment),
        .i_level         (w_level),
        .o_push          (w_push)
    );

    // The queue absorbs the beats in flight when the output side stalls.
    rpsb_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_level (w_level)
    );

    // The back holds the best score state; each popped pair updates it in
    // the cycle after the pop, so a tie or a new best is visible to the very next pair.
    rpsb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pair_score     (o_pair_score),
        .o_pair_count     (o_pair_count),
        .o_concordant     (o_concordant),
        .o_kept           (o_kept),
        .o_best_score_out (o_best_score_out),
        .o_best_count_out (o_best_count_out),
        .o_any_concordant (o_any_concordant)
    );

endmodule

// ----- hw/rtl/rpsb_checker.sv -----
// Port-level checks on the read pair score tracker, bound to the top level.
module rpsb_checker
    import rpsb_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [31:0]      o_pair_score,
    input logic                    o_pair_count,
    input logic                    o_concordant,
    input logic                    o_kept,
    input logic signed [31:0]      o_best_score_out,
    input logic [15:0]             o_best_count_out,
    input logic                    o_any_concordant
);

    // A kept pair has become or matched the best score.
    a_kept_is_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kept |-> o_best_score_out == o_pair_score)
        else $error("kept pair does not equal best score");

    // A rejected pair lies strictly below the best score.
    a_reject_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kept |-> o_best_score_out > o_pair_score)
        else $error("rejected pair is not below best score");

    // Only a counted pair can be concordant.
    a_conc_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_concordant |-> o_pair_count)
        else $error("concordant pair without count");

    // A stalled result beat stays valid and keeps every field.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pair_score) &&
        $stable(o_pair_count) && $stable(o_concordant) && $stable(o_kept) &&
        $stable(o_best_score_out) && $stable(o_best_count_out) &&
        $stable(o_any_concordant))
        else $error("stalled result beat changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

endmodule

bind read_pair_score_best_tracker rpsb_checker u_rpsb_checker (.*);
